// ----- src/lpht_pkg.sv -----
// Package for the linear-probe hash table: marks, request and status codes,
// sequencer states and hash constants. No dependencies.
package lpht_pkg;

  localparam logic [63:0] HASH_SEED = 64'h012345678abcdefa;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_USED  = 2'd1,
    MARK_TOMB  = 2'd2,
    MARK_RSVD  = 2'd3
  } mark_t;

  localparam logic [1:0] REQ_GET  = 2'd0;
  localparam logic [1:0] REQ_PUT  = 2'd1;
  localparam logic [1:0] REQ_DEL  = 2'd2;
  localparam logic [1:0] REQ_RSVD = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_MOD, S_RD, S_CMP, S_WRITE, S_DONE
  } state_t;

endpackage

// ----- src/lpht_mod.sv -----
// Iterative remainder unit: 64-bit dividend modulo a 17-bit divisor, one
// quotient bit a cycle (restoring). Depends on nothing but the package style.
module lpht_mod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] dividend,
  input  logic [16:0] divisor,
  output logic        done,
  output logic [16:0] remainder
);
  logic [63:0] num_r, num_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [17:0] trial;

  // Shift one dividend bit in and subtract the divisor where it fits.
  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[16:0], num_r[63]};
    if (go) begin
      num_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = 7'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[62:0], 1'b0};
      rem_nxt = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = busy_r && (cnt_r == 7'd63) && !go;
  assign remainder = rem_nxt[16:0];
endmodule

// ----- src/linear_probe_hash_table_top.sv -----
// Top level of the linear-probe hash table: APB register, sequencer, slot
// memories, hash step and probe walk. Depends on lpht_pkg and lpht_mod.
//
// Channel | Ports                                  | Handshake
// input   | in_req_type in_key_bytes in_key_length | start & !busy
//         | in_put_value                           |
// result  | out_status out_slot_index ...          | out_valid, one cycle
// config  | psel penable pwrite paddr pwdata       | APB, pready high
//
// An item passes through the hash step over its key bytes, the bit-serial
// remainder unit, a read and a compare per probed slot, and then the write
// and result states. A request of type three skips the probe and the write.
// After reset a clearing pass marks every slot empty in turn; busy stays
// high then.
// The receiver cannot stall: each result shows for one cycle.
module linear_probe_hash_table_top #(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_BYTES   = 8,
  parameter int VALUE_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [63:0] in_key_bytes,
  input  logic [3:0]  in_key_length,
  input  logic [31:0] in_put_value,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [7:0]  out_slot_index,
  output logic [31:0] out_read_value,
  output logic [8:0]  out_live_count
);
  import lpht_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = $clog2(KEY_BYTES + 1);
  localparam int KB = 8 * KEY_BYTES;

  // Slot memories.
  logic [1:0]            mark_mem [TABLE_DEPTH];
  logic [KB-1:0]         key_mem  [TABLE_DEPTH];
  logic [LW-1:0]         len_mem  [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] val_mem  [TABLE_DEPTH];
  logic [1:0]            rd_mark_r;
  logic [KB-1:0]         rd_key_r;
  logic [LW-1:0]         rd_len_r;
  logic [VALUE_BITS-1:0] rd_val_r;

  state_t state_r, state_nxt;
  logic [8:0]            cap_reg_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic [1:0]            req_r;
  logic [KB-1:0]         key_r;
  logic [LW-1:0]         len_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [63:0]           hash_r, hash_nxt;
  logic [LW-1:0]         bidx_r, bidx_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [CW-1:0]         steps_r, steps_nxt;
  logic                  found_r, found_nxt;
  logic                  hfree_r, hfree_nxt;
  logic [AW-1:0]         free_r, free_nxt;
  logic [AW-1:0]         clr_r, clr_nxt;
  logic [1:0]            st_r, st_nxt;
  logic [AW-1:0]         slot_r, slot_nxt;
  logic [VALUE_BITS-1:0] rval_r, rval_nxt;
  logic                  ov_r, ov_nxt;

  logic [CW-1:0]  cap;
  logic [3:0]     len_in;
  logic [7:0]     cur_byte;
  logic           mod_go, mod_done;
  logic [16:0]    mod_rem;
  logic           accept;
  logic           mem_we;
  logic [AW-1:0]  mem_wa;
  logic [1:0]     mem_wmark;
  logic           mem_wfull;
  logic           cfg_wr;
  logic [AW-1:0]  pos_inc;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == 1'b0);
  assign prdata = (paddr == 1'b0) ? {23'd0, cap_reg_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) cap_reg_r <= 9'd256;
    else if (cfg_wr) cap_reg_r <= pwdata[8:0];
  end

  // Effective capacity, clamped to one and the depth.
  always_comb begin
    if (cap_reg_r == 9'd0) cap = CW'(1);
    else if (32'(cap_reg_r) > TABLE_DEPTH) cap = CW'(TABLE_DEPTH);
    else cap = CW'(cap_reg_r);
  end

  always_comb begin
    if (in_key_length == 4'd0) len_in = 4'd1;
    else if (32'(in_key_length) > KEY_BYTES) len_in = 4'(KEY_BYTES);
    else len_in = in_key_length;
  end

  assign accept   = start && !busy;
  assign busy     = (state_r != S_IDLE);
  assign cur_byte = key_r[8*bidx_r +: 8];
  assign pos_inc  = (32'(pos_r) + 1 >= 32'(cap)) ? '0 : AW'(pos_r + 1'b1);

  // The remainder starts on the hash that includes the last key byte.
  lpht_mod u_mod (
    .clk(clk), .rst_n(rst_n), .go(mod_go), .dividend(hash_nxt),
    .divisor(17'(cap)), .done(mod_done), .remainder(mod_rem)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    hash_nxt  = hash_r;
    bidx_nxt  = bidx_r;
    pos_nxt   = pos_r;
    steps_nxt = steps_r;
    found_nxt = found_r;
    hfree_nxt = hfree_r;
    free_nxt  = free_r;
    clr_nxt   = clr_r;
    st_nxt    = st_r;
    slot_nxt  = slot_r;
    rval_nxt  = rval_r;
    ov_nxt    = 1'b0;
    mod_go    = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = pos_r;
    mem_wmark = MARK_EMPTY;
    mem_wfull = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == TABLE_DEPTH - 1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          hash_nxt  = HASH_SEED;
          bidx_nxt  = '0;
          found_nxt = 1'b0;
          hfree_nxt = 1'b0;
          steps_nxt = '0;
          st_nxt    = ST_MISSING;
          slot_nxt  = '0;
          rval_nxt  = '0;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        hash_nxt = ((hash_r ^ {56'd0, cur_byte}) << 8) + {56'd0, cur_byte};
        bidx_nxt = bidx_r + 1'b1;
        if (bidx_r + 1'b1 == len_r) begin
          state_nxt = S_MOD;
          mod_go = 1'b1;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          pos_nxt = AW'(mod_rem);
          state_nxt = (req_r == REQ_RSVD) ? S_DONE : S_RD;
        end
      end
      S_RD: state_nxt = S_CMP;
      S_CMP: begin
        steps_nxt = steps_r + 1'b1;
        state_nxt = S_RD;
        pos_nxt   = pos_inc;
        priority if (rd_mark_r == MARK_EMPTY) begin
          if (!hfree_r) begin
            hfree_nxt = 1'b1;
            free_nxt = pos_r;
          end
          pos_nxt = pos_r;
          state_nxt = S_WRITE;
        end else if (rd_mark_r == MARK_TOMB) begin
          if (!hfree_r) begin
            hfree_nxt = 1'b1;
            free_nxt = pos_r;
          end
        end else if (rd_mark_r == MARK_USED && rd_len_r == len_r && rd_key_r == key_r)
        begin
          found_nxt = 1'b1;
          pos_nxt = pos_r;
          state_nxt = S_WRITE;
        end
        if (state_nxt == S_RD && steps_r + 1'b1 == cap) state_nxt = S_WRITE;
      end
      S_WRITE: begin
        state_nxt = S_DONE;
        if (found_r) begin
          st_nxt = ST_OK;
          slot_nxt = pos_r;
          if (req_r == REQ_GET) rval_nxt = rd_val_r;
          else if (req_r == REQ_DEL) begin
            mem_we = 1'b1;
            mem_wmark = MARK_TOMB;
            if (count_r != '0) count_nxt = count_r - 1'b1;
          end else begin
            mem_we = 1'b1;
            mem_wmark = MARK_USED;
            mem_wfull = 1'b1;
          end
        end else if (req_r == REQ_PUT) begin
          if (hfree_r) begin
            st_nxt = ST_OK;
            slot_nxt = free_r;
            mem_we = 1'b1;
            mem_wa = free_r;
            mem_wmark = MARK_USED;
            mem_wfull = 1'b1;
            count_nxt = count_r + 1'b1;
          end else st_nxt = ST_FULL;
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
    hash_r  <= hash_nxt;
    bidx_r  <= bidx_nxt;
    pos_r   <= pos_nxt;
    steps_r <= steps_nxt;
    found_r <= found_nxt;
    hfree_r <= hfree_nxt;
    free_r  <= free_nxt;
    st_r    <= st_nxt;
    slot_r  <= slot_nxt;
    rval_r  <= rval_nxt;
  end

  // Captured request item.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req_type;
      len_r <= LW'(len_in);
      key_r <= KB'(in_key_bytes & ((len_in >= 4'd8) ? 64'hffffffffffffffff
                                   : ((64'd1 << {len_in, 3'b000}) - 64'd1)));
      val_r <= VALUE_BITS'(in_put_value);
    end
  end

  // Slot memories: one write, one registered read a cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mark_mem[mem_wa] <= mem_wmark;
      if (mem_wfull) begin
        val_mem[mem_wa] <= val_r;
        if (!found_r) begin
          key_mem[mem_wa] <= key_r;
          len_mem[mem_wa] <= len_r;
        end
      end
    end
    rd_mark_r <= mark_mem[pos_r];
    rd_key_r  <= key_mem[pos_r];
    rd_len_r  <= len_mem[pos_r];
    rd_val_r  <= val_mem[pos_r];
  end

  // Result item.
  assign out_valid      = ov_r;
  assign out_status     = st_r;
  assign out_slot_index = 8'(32'(slot_r));
  assign out_read_value = 32'(rval_r);
  assign out_live_count = 9'(count_r);
endmodule

// ----- tb/sv/lpht_checker.sv -----
// Checker for the linear-probe hash table: watches the request and result
// channels and the register port, predicts each result and compares it.
// Depends on lpht_pkg.
module lpht_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [63:0] in_key_bytes,
  input  logic [3:0]  in_key_length,
  input  logic [31:0] in_put_value,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [7:0]  out_slot_index,
  input  logic [31:0] out_read_value,
  input  logic [8:0]  out_live_count,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);
  import lpht_pkg::*;

  localparam int DEPTH = 256;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slot_index;
    logic [31:0] read_value;
    logic [8:0]  live_count;
  } lookup_result_t;

  // Shadow copy of the table and its capacity register.
  mark_t        shadow_mark [DEPTH];
  logic [63:0]  shadow_key [DEPTH];
  logic [3:0]   shadow_len [DEPTH];
  logic [31:0]  shadow_value [DEPTH];
  logic [8:0]   shadow_count;
  logic [8:0]   shadow_capacity;
  lookup_result_t awaited_results[$];

  function automatic logic [63:0] seeded_hash(logic [63:0] key, int len);
    logic [63:0] h;
    logic [63:0] b;
    h = HASH_SEED;
    for (int i = 0; i < len; i++) begin
      b = (key >> (8 * i)) & 64'hff;
      h = h ^ b;
      h = h << 8;
      h = h + b;
    end
    return h;
  endfunction

  // Walks the probe sequence (not for a reserved request), updates the shadow table and forms the result.
  function automatic lookup_result_t apply_request(logic [1:0] req, logic [63:0] raw_key,
                                                   logic [3:0] raw_len, logic [31:0] value);
    lookup_result_t r;
    int cap, len, start_slot, p, pos, free_pos;
    bit found, have_free;
    logic [63:0] key;
    cap = int'(shadow_capacity);
    if (cap == 0) cap = 1;
    if (cap > DEPTH) cap = DEPTH;
    len = int'(raw_len);
    if (len == 0) len = 1;
    if (len > 8) len = 8;
    key = (len == 8) ? raw_key : raw_key & ((64'd1 << (8 * len)) - 1);
    start_slot = int'(seeded_hash(key, len) % 64'(cap));
    found = 0;
    have_free = 0;
    pos = 0;
    free_pos = 0;
    r = '0;
    r.status = ST_MISSING;
    if (req != REQ_RSVD) begin
      for (int i = 0; i < cap; i++) begin
        p = (start_slot + i) % cap;
        if (shadow_mark[p] == MARK_EMPTY) begin
          if (!have_free) begin
            have_free = 1;
            free_pos = p;
          end
          break;
        end
        if (shadow_mark[p] == MARK_TOMB) begin
          if (!have_free) begin
            have_free = 1;
            free_pos = p;
          end
          continue;
        end
        if (shadow_mark[p] == MARK_USED && shadow_len[p] == len && shadow_key[p] == key) begin
          found = 1;
          pos = p;
          break;
        end
      end
      if (req == REQ_GET) begin
        if (found) begin
          r.status = ST_OK;
          r.slot_index = pos[7:0];
          r.read_value = shadow_value[pos];
        end
      end else if (req == REQ_DEL) begin
        if (found) begin
          shadow_mark[pos] = MARK_TOMB;
          if (shadow_count > 0) shadow_count--;
          r.status = ST_OK;
          r.slot_index = pos[7:0];
        end
      end else begin
        if (found) begin
          shadow_value[pos] = value;
          r.status = ST_OK;
          r.slot_index = pos[7:0];
        end else if (have_free) begin
          shadow_mark[free_pos] = MARK_USED;
          shadow_key[free_pos] = key;
          shadow_len[free_pos] = len[3:0];
          shadow_value[free_pos] = value;
          shadow_count++;
          r.status = ST_OK;
          r.slot_index = free_pos[7:0];
        end else begin
          r.status = ST_FULL;
        end
      end
    end
    r.live_count = shadow_count;
    return r;
  endfunction

  // Capture register writes and accepted items; compare each result.
  always @(posedge clk) begin
    lookup_result_t seen;
    lookup_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) shadow_mark[i] = MARK_EMPTY;
      shadow_count = 0;
      shadow_capacity = 9'd256;
      awaited_results.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == 1'b0)
        shadow_capacity = pwdata[8:0];
      if (out_valid) begin
        seen = '{out_status, out_slot_index, out_read_value, out_live_count};
        result_count++;
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("Unexpected result %p", seen);
        end else begin
          want = awaited_results.pop_front();
          if (seen !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("Mismatch: expected %p, got %p", want, seen);
          end
        end
      end
      if (start && !busy)
        awaited_results.push_back(apply_request(in_req_type, in_key_bytes,
                                                in_key_length, in_put_value));
    end
    pending_count = awaited_results.size();
  end
endmodule

// ----- tb/sv/tb_linear_probe_hash_table_top.sv -----
// Testbench top for the linear-probe hash table: clock, reset, register
// writes and request stimulus; verdict from lpht_checker. Depends on lpht_pkg.
module tb_linear_probe_hash_table_top;
  import lpht_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        psel = 0, penable = 0, pwrite = 0, paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 0;
  logic        busy;
  logic [1:0]  in_req_type = 0;
  logic [63:0] in_key_bytes = 0;
  logic [3:0]  in_key_length = 1;
  logic [31:0] in_put_value = 0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [7:0]  out_slot_index;
  logic [31:0] out_read_value;
  logic [8:0]  out_live_count;
  int          fail_count, pending_count, result_count;
  int          gap_percent;
  logic [63:0] key_pool [16];
  logic [3:0]  len_pool [16];

  always #10 clk = ~clk;

  linear_probe_hash_table_top dut (.*);
  lpht_checker u_checker (.*);

  // Timeout guard.
  initial begin
    #200_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic write_capacity(input int cap);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 1'b0;
    pwdata <= cap;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // The first edge keeps start low between the previous item and this one.
  task automatic issue_request(input logic [1:0] req, input logic [63:0] key,
                               input logic [3:0] len, input logic [31:0] value);
    int gap;
    gap = 0;
    @(posedge clk);
    while ($urandom_range(99) < gap_percent && gap < 20) begin
      @(posedge clk);
      gap++;
    end
    start <= 1'b1;
    in_req_type <= req;
    in_key_bytes <= key;
    in_key_length <= len;
    in_put_value <= value;
    do @(posedge clk); while (busy);
    start <= 1'b0;
  endtask

  // Let the block settle so no write lands mid-request.
  task automatic drain_requests();
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [1:0] pick_request();
    int r;
    r = $urandom_range(99);
    if (r < 45) return REQ_PUT;
    if (r < 75) return REQ_GET;
    if (r < 97) return REQ_DEL;
    return REQ_RSVD;
  endfunction

  // Random phase: keys mostly drawn from a small pool so gets and deletes hit.
  task automatic random_phase(input int count, input int cap);
    int k;
    write_capacity(cap);
    for (int i = 0; i < 16; i++) begin
      key_pool[i] = {$urandom, $urandom};
      len_pool[i] = 4'($urandom_range(1, 8));
    end
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(15);
      if ($urandom_range(9) == 0)
        issue_request(pick_request(), {$urandom, $urandom}, 4'($urandom_range(15)),
                      $urandom);
      else
        issue_request(pick_request(), key_pool[k], len_pool[k], $urandom);
    end
    drain_requests();
  endtask

  initial begin
    int caps [7] = '{1, 2, 3, 7, 16, 256, 0};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    gap_percent = 6;
    // Directed: fill a one-slot table, overflow it, tombstone reuse, odd codes.
    write_capacity(1);
    issue_request(REQ_GET, 64'h61, 1, 0);
    issue_request(REQ_PUT, 64'h61, 1, 32'hffff_ffff);
    issue_request(REQ_PUT, 64'h62, 1, 1);
    issue_request(REQ_PUT, 64'h61, 1, 32'h0);
    issue_request(REQ_GET, 64'h61, 1, 0);
    issue_request(REQ_DEL, 64'h61, 1, 0);
    issue_request(REQ_DEL, 64'h61, 1, 0);
    issue_request(REQ_PUT, 64'h62, 0, 5);
    issue_request(REQ_GET, 64'hff62, 1, 0);
    issue_request(REQ_RSVD, 64'h62, 1, 0);
    drain_requests();
    write_capacity(511);
    issue_request(REQ_PUT, 64'hffff_ffff_ffff_ffff, 8, 32'h1234_5678);
    issue_request(REQ_PUT, 64'hffff_ffff_ffff_ffff, 15, 32'h9);
    issue_request(REQ_GET, 64'hffff_ffff_ffff_ffff, 8, 0);
    issue_request(REQ_PUT, 64'h0, 8, 32'h77);
    issue_request(REQ_PUT, 64'h0, 3, 32'h78);
    issue_request(REQ_GET, 64'h0, 8, 0);
    issue_request(REQ_DEL, 64'h0, 3, 0);
    issue_request(REQ_GET, 64'h0, 3, 0);
    issue_request(REQ_PUT, 64'h5555_aaaa_5555_aaaa, 8, 32'haaaa_5555);
    issue_request(REQ_GET, 64'haaaa_5555_aaaa_5555, 8, 0);
    drain_requests();
    // Random phases over several capacities and idling mixes.
    for (int p = 0; p < 7; p++) begin
      gap_percent = (p < 3) ? 6 : (p < 5) ? 62 : 0;
      random_phase(100, caps[p]);
    end
    repeat (200) @(posedge clk);
    $display("Covered %0d results over capacities 0 to 511, tombstones and full tables.",
             result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
